// ----- rtl/uartr_pkg.sv -----
// Shared types and constants for the UART register and interrupt unit.
package uartr_pkg;

  // Item commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;
  localparam logic [1:0] CMD_ARRIVE = 2'd3;

  // Register offsets
  localparam logic [2:0] ADDR_DATA = 3'd0;
  localparam logic [2:0] ADDR_IER  = 3'd1;
  localparam logic [2:0] ADDR_IIR  = 3'd2;
  localparam logic [2:0] ADDR_LCR  = 3'd3;
  localparam logic [2:0] ADDR_MCR  = 3'd4;
  localparam logic [2:0] ADDR_LSR  = 3'd5;
  localparam logic [2:0] ADDR_MSR  = 3'd6;
  localparam logic [2:0] ADDR_SCR  = 3'd7;

  // Fixed register values
  localparam logic [7:0] IIR_RX      = 8'h04;
  localparam logic [7:0] IIR_TX      = 8'h02;
  localparam logic [7:0] IIR_NONE    = 8'h01;
  localparam logic [7:0] LSR_BASE    = 8'h60;
  localparam logic [7:0] MCR_MATCH   = 8'h1A;
  localparam logic [7:0] MCR_STORED  = 8'h9A;
  localparam logic [7:0] TICKS_MAX   = 8'hFF;

  localparam int unsigned DELAY_TICKS_DEF = 225;

  // One input word
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic       rx_ready;
    logic       rx_more;
    logic [7:0] rx_byte;
  } item_t;

  // One result word
  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_take;
    logic       irq_post;
    logic       irq_clear;
  } result_t;

endpackage

// ----- rtl/uartr_core.sv -----
// Register file, interrupt countdowns and per-word decode of the UART unit.
module uartr_core #(
  parameter int unsigned DELAY_TICKS = uartr_pkg::DELAY_TICKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              commit,
  input  uartr_pkg::item_t  item,
  output uartr_pkg::result_t res
);
  import uartr_pkg::*;

  localparam logic [7:0] DELAY = 8'(DELAY_TICKS);

  logic [7:0] int_enable, line_control, modem_control, divisor_low;
  logic [7:0] divisor_high, fifo_control, scratch_byte;
  logic [1:0] pending_flags;
  logic [7:0] rx_countdown, tx_countdown, ticks_since_tx_int;

  logic [7:0] int_enable_next, line_control_next, modem_control_next, divisor_low_next;
  logic [7:0] divisor_high_next, fifo_control_next, scratch_byte_next;
  logic [1:0] pending_flags_next;
  logic [7:0] rx_countdown_next, tx_countdown_next, ticks_since_tx_int_next;

  logic dlab;
  assign dlab = line_control[7];

  // Decode one word against the current register state
  always_comb begin
    int_enable_next         = int_enable;
    line_control_next       = line_control;
    modem_control_next      = modem_control;
    divisor_low_next        = divisor_low;
    divisor_high_next       = divisor_high;
    fifo_control_next       = fifo_control;
    scratch_byte_next       = scratch_byte;
    pending_flags_next      = pending_flags;
    rx_countdown_next       = rx_countdown;
    tx_countdown_next       = tx_countdown;
    ticks_since_tx_int_next = ticks_since_tx_int;
    res                     = '0;

    unique case (item.cmd)
      CMD_TICK: begin
        if (ticks_since_tx_int != TICKS_MAX) begin
          ticks_since_tx_int_next = ticks_since_tx_int + 8'd1;
        end
        // RX countdown; a fire restarts the tick count
        if (rx_countdown != 8'd0) begin
          rx_countdown_next = rx_countdown - 8'd1;
          if (rx_countdown == 8'd1 && int_enable[0]) begin
            pending_flags_next[0]   = 1'b1;
            ticks_since_tx_int_next = 8'd0;
            res.irq_post            = 1'b1;
          end
        end
        // TX countdown
        if (tx_countdown != 8'd0) begin
          tx_countdown_next = tx_countdown - 8'd1;
          if (tx_countdown == 8'd1 && int_enable[1]) begin
            pending_flags_next[1]   = 1'b1;
            ticks_since_tx_int_next = 8'd0;
            res.irq_post            = 1'b1;
          end
        end
      end

      CMD_ARRIVE: begin
        if (int_enable[0]) begin
          res.irq_post          = 1'b1;
          pending_flags_next[0] = 1'b1;
        end
      end

      CMD_READ: begin
        unique case (item.reg_addr)
          ADDR_DATA: begin
            if (dlab) begin
              res.read_data = divisor_low;
            end else begin
              if (item.rx_ready) begin
                res.read_data = item.rx_byte;
                res.rx_take   = 1'b1;
              end
              pending_flags_next[0] = 1'b0;
              res.irq_clear         = 1'b1;
              if (item.rx_ready && item.rx_more && int_enable[0]) begin
                rx_countdown_next = DELAY;
              end
            end
          end
          ADDR_IER: res.read_data = dlab ? divisor_high : int_enable;
          ADDR_IIR: begin
            priority if (pending_flags[0]) begin
              res.read_data = IIR_RX;
            end else if (pending_flags[1]) begin
              res.read_data         = IIR_TX;
              pending_flags_next[1] = 1'b0;
            end else begin
              res.read_data = IIR_NONE;
            end
          end
          ADDR_LCR: res.read_data = line_control;
          ADDR_MCR: res.read_data = modem_control;
          ADDR_LSR: res.read_data = LSR_BASE | {7'd0, item.rx_ready};
          ADDR_MSR: res.read_data = 8'd0;
          ADDR_SCR: res.read_data = scratch_byte;
          default:  res.read_data = 8'd0;
        endcase
      end

      CMD_WRITE: begin
        unique case (item.reg_addr)
          ADDR_DATA: begin
            if (dlab) begin
              divisor_low_next = item.write_data;
            end else begin
              res.tx_valid          = 1'b1;
              res.tx_byte           = item.write_data;
              res.irq_clear         = 1'b1;
              pending_flags_next[1] = 1'b0;
              if (int_enable[1]) begin
                tx_countdown_next = DELAY;
              end
            end
          end
          ADDR_IER: begin
            if (dlab) begin
              divisor_high_next = item.write_data;
            end else begin
              int_enable_next = item.write_data;
              // TX enable: fire at once when the line has been quiet long enough
              if (item.write_data[1]) begin
                if (ticks_since_tx_int > DELAY) begin
                  pending_flags_next[1]   = 1'b1;
                  ticks_since_tx_int_next = 8'd0;
                  res.irq_post            = 1'b1;
                end else begin
                  tx_countdown_next = DELAY;
                end
              end else begin
                tx_countdown_next     = 8'd0;
                pending_flags_next[1] = 1'b0;
                if (pending_flags[1]) res.irq_clear = 1'b1;
              end
              // RX enable
              if (item.write_data[0] && item.rx_ready) begin
                rx_countdown_next = DELAY;
              end else begin
                rx_countdown_next     = 8'd0;
                pending_flags_next[0] = 1'b0;
                if (pending_flags[0]) res.irq_clear = 1'b1;
              end
            end
          end
          ADDR_IIR: fifo_control_next = item.write_data;
          ADDR_LCR: line_control_next = item.write_data;
          ADDR_MCR: begin
            if (item.write_data == MCR_MATCH) modem_control_next = MCR_STORED;
          end
          ADDR_SCR: scratch_byte_next = item.write_data;
          default: ;
        endcase
      end

      default: ;
    endcase
  end

  // State registers, updated when a word is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable         <= '0;
      line_control       <= '0;
      modem_control      <= '0;
      divisor_low        <= '0;
      divisor_high       <= '0;
      fifo_control       <= '0;
      scratch_byte       <= '0;
      pending_flags      <= '0;
      rx_countdown       <= '0;
      tx_countdown       <= '0;
      ticks_since_tx_int <= '0;
    end else if (commit) begin
      int_enable         <= int_enable_next;
      line_control       <= line_control_next;
      modem_control      <= modem_control_next;
      divisor_low        <= divisor_low_next;
      divisor_high       <= divisor_high_next;
      fifo_control       <= fifo_control_next;
      scratch_byte       <= scratch_byte_next;
      pending_flags      <= pending_flags_next;
      rx_countdown       <= rx_countdown_next;
      tx_countdown       <= tx_countdown_next;
      ticks_since_tx_int <= ticks_since_tx_int_next;
    end
  end

endmodule

// ----- rtl/uart_register_and_interrupt_unit.sv -----
// Top level of the 8250-style UART register and interrupt unit.
//
// Input channel (in_valid/in_ready) carries one word per tick, bus read,
// bus write or receive-arrival notice. Output channel (out_valid/out_ready)
// returns exactly one result word per input word, in order.
// A word is taken into an input register, decoded against the register
// file in one pass, and its result lands in an output register.
// Throughput: one word per cycle while out_ready is high; the register
// file update and decode are combinational, so nothing else limits it.
// When the receiver stalls, the output register holds its word and the
// input register fills; in_ready drops only once both are occupied, and
// rises again in the cycle the output word is taken.
// Reset clears all registers, countdowns and pending interrupt flags and
// empties both pipeline registers. DELAY_TICKS (1..254) sets the interrupt
// delay in ticks.
module uart_register_and_interrupt_unit #(
  parameter int unsigned DELAY_TICKS = uartr_pkg::DELAY_TICKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [2:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic       rx_ready,
  input  logic       rx_more,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       rx_take,
  output logic       irq_post,
  output logic       irq_clear
);
  import uartr_pkg::*;

  logic    item_valid;
  item_t   item;
  result_t res;
  result_t res_q;
  logic    advance;

  // Pipeline moves when the output slot is free or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{cmd: cmd, reg_addr: reg_addr, write_data: write_data,
                rx_ready: rx_ready, rx_more: rx_more, rx_byte: rx_byte};
    end
  end

  uartr_core #(
    .DELAY_TICKS(DELAY_TICKS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .commit(item_valid && advance),
    .item  (item),
    .res   (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      res_q <= res;
    end
  end

  assign read_data = res_q.read_data;
  assign tx_valid  = res_q.tx_valid;
  assign tx_byte   = res_q.tx_byte;
  assign rx_take   = res_q.rx_take;
  assign irq_post  = res_q.irq_post;
  assign irq_clear = res_q.irq_clear;

  // A transmit word never carries read data or a receive take
  assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid |-> read_data == 8'd0 && !rx_take)
    else $error("transmit word carries read side effects");

  // Taking a receive byte always clears the interrupt
  assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_take |-> irq_clear)
    else $error("receive take without interrupt clear");

  // Transmit byte is zero unless a byte is handed over
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == 8'd0)
    else $error("stray transmit byte");

  // A word in the input register reaches the output once the output drains
  assert property (@(posedge clk) disable iff (rst)
    item_valid && advance |=> out_valid)
    else $error("word lost between pipeline registers");

endmodule

// ----- tb/sv/uart_register_and_interrupt_unit_test.sv -----
// Self-checking testbench for the UART register and interrupt unit.
module uart_register_and_interrupt_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uartr_pkg::*;

  localparam int unsigned DELAY         = DELAY_TICKS_DEF;
  localparam logic [7:0]  DELAY_COUNT   = 8'(DELAY);
  localparam int          IER_RX        = 0;
  localparam int          IER_TX        = 1;
  localparam int          LCR_DLAB      = 7;
  localparam int          ITEM_BITS     = $bits(item_t);
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned PHASE_WORDS   = 105;
  localparam int unsigned MAX_REPORTS   = 40;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic [1:0] cmd        = '0;
  logic [2:0] reg_addr   = '0;
  logic [7:0] write_data = '0;
  logic       rx_ready   = 1'b0;
  logic       rx_more    = 1'b0;
  logic [7:0] rx_byte    = '0;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_take;
  logic       irq_post;
  logic       irq_clear;

  // Traffic shaping, percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Bookkeeping
  result_t     awaited_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned posts_checked = 0;
  int unsigned clears_checked = 0;
  int unsigned words_sent = 0;
  int unsigned words_by_cmd[4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;

  // Shadow copy of the register file and interrupt state
  logic [7:0] ier_m = '0, lcr_m = '0, mcr_m = '0, dll_m = '0;
  logic [7:0] dlh_m = '0, fcr_m = '0, scr_m = '0;
  logic       rx_pend_m = 1'b0, tx_pend_m = 1'b0;
  logic [7:0] rx_count_m = '0, tx_count_m = '0, ticks_since_tx_m = '0;

  always #10 clk = ~clk;

  uart_register_and_interrupt_unit #(.DELAY_TICKS(DELAY)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .reg_addr  (reg_addr),
    .write_data(write_data),
    .rx_ready  (rx_ready),
    .rx_more   (rx_more),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .rx_take   (rx_take),
    .irq_post  (irq_post),
    .irq_clear (irq_clear)
  );

  // Interrupt fires only when enabled; a fire restarts the TX quiet counter
  function automatic logic raise_irq(input int ier_bit);
    if (ier_m[ier_bit]) begin
      if (ier_bit == IER_TX) tx_pend_m = 1'b1;
      else rx_pend_m = 1'b1;
      ticks_since_tx_m = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the shadow state by one word and return the result it causes
  function automatic result_t uart_next_result(input item_t w);
    result_t r;
    logic    dlab;
    r = '0;
    dlab = lcr_m[LCR_DLAB];
    case (w.cmd)
      CMD_TICK: begin
        if (ticks_since_tx_m != TICKS_MAX) ticks_since_tx_m++;
        if (rx_count_m != 8'd0) begin
          rx_count_m--;
          if (rx_count_m == 8'd0) r.irq_post |= raise_irq(IER_RX);
        end
        if (tx_count_m != 8'd0) begin
          tx_count_m--;
          if (tx_count_m == 8'd0) r.irq_post |= raise_irq(IER_TX);
        end
      end
      CMD_ARRIVE: begin
        // arrival ignores rx_ready
        if (ier_m[IER_RX]) begin
          r.irq_post = 1'b1;
          rx_pend_m  = 1'b1;
        end
      end
      CMD_READ: begin
        case (w.reg_addr)
          ADDR_DATA: begin
            if (dlab) begin
              r.read_data = dll_m;
            end else begin
              if (w.rx_ready) begin
                r.read_data = w.rx_byte;
                r.rx_take   = 1'b1;
              end
              rx_pend_m   = 1'b0;
              r.irq_clear = 1'b1;
              if (w.rx_ready && w.rx_more && ier_m[IER_RX]) rx_count_m = DELAY_COUNT;
            end
          end
          ADDR_IER: r.read_data = dlab ? dlh_m : ier_m;
          ADDR_IIR: begin
            // RX outranks TX; reading out TX acknowledges it
            if (rx_pend_m) begin
              r.read_data = IIR_RX;
            end else if (tx_pend_m) begin
              r.read_data = IIR_TX;
              tx_pend_m   = 1'b0;
            end else begin
              r.read_data = IIR_NONE;
            end
          end
          ADDR_LCR: r.read_data = lcr_m;
          ADDR_MCR: r.read_data = mcr_m;
          ADDR_LSR: r.read_data = LSR_BASE | {7'd0, w.rx_ready};
          ADDR_MSR: r.read_data = '0;
          default:  r.read_data = scr_m;
        endcase
      end
      CMD_WRITE: begin
        case (w.reg_addr)
          ADDR_DATA: begin
            if (dlab) begin
              dll_m = w.write_data;
            end else begin
              r.tx_valid  = 1'b1;
              r.tx_byte   = w.write_data;
              r.irq_clear = 1'b1;
              tx_pend_m   = 1'b0;
              if (ier_m[IER_TX]) tx_count_m = DELAY_COUNT;
            end
          end
          ADDR_IER: begin
            if (dlab) begin
              dlh_m = w.write_data;
            end else begin
              ier_m = w.write_data;
              // TX enable: fire at once if the line has been quiet long enough
              if (w.write_data[IER_TX]) begin
                if (ticks_since_tx_m > DELAY_COUNT) r.irq_post |= raise_irq(IER_TX);
                else tx_count_m = DELAY_COUNT;
              end else begin
                tx_count_m = '0;
                if (tx_pend_m) r.irq_clear = 1'b1;
                tx_pend_m = 1'b0;
              end
              if (w.write_data[IER_RX] && w.rx_ready) begin
                rx_count_m = DELAY_COUNT;
              end else begin
                rx_count_m = '0;
                if (rx_pend_m) r.irq_clear = 1'b1;
                rx_pend_m = 1'b0;
              end
            end
          end
          ADDR_IIR: fcr_m = w.write_data;
          ADDR_LCR: lcr_m = w.write_data;
          ADDR_MCR: if (w.write_data == MCR_MATCH) mcr_m = MCR_STORED;
          ADDR_SCR: scr_m = w.write_data;
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic coin();
    return 1'($urandom);
  endfunction

  function automatic item_t random_word();
    item_t w;
    w = item_t'(ITEM_BITS'($urandom));
    return w;
  endfunction

  // Present one word, hold it until taken, then record its expected result
  task automatic send_word(input item_t w);
    result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {cmd, reg_addr, write_data, rx_ready, rx_more, rx_byte} <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = uart_next_result(w);
    awaited_results = {awaited_results, want};
    words_by_cmd[w.cmd]++;
    words_sent++;
  endtask

  task automatic bus_write(input logic [2:0] addr, input logic [7:0] data,
                           input logic ready);
    item_t w;
    w = random_word();
    w.cmd        = CMD_WRITE;
    w.reg_addr   = addr;
    w.write_data = data;
    w.rx_ready   = ready;
    send_word(w);
  endtask

  task automatic bus_read(input logic [2:0] addr, input logic ready, input logic more);
    item_t w;
    w = random_word();
    w.cmd      = CMD_READ;
    w.reg_addr = addr;
    w.rx_ready = ready;
    w.rx_more  = more;
    send_word(w);
  endtask

  task automatic rx_arrival();
    item_t w;
    w = random_word();
    w.cmd = CMD_ARRIVE;
    send_word(w);
  endtask

  task automatic run_ticks(input int unsigned n);
    item_t w;
    repeat (n) begin
      w = random_word();
      w.cmd = CMD_TICK;
      send_word(w);
    end
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_all_results();
    if (awaited_results.size() != 0) begin
      in_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
               $realtime, results_checked, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("word with none outstanding", int'(read_data), 0);
      return;
    end
    want = awaited_results.pop_front();
    if (read_data !== want.read_data)
      report_mismatch("read_data", int'(read_data), int'(want.read_data));
    if (tx_valid  !== want.tx_valid)
      report_mismatch("tx_valid",  int'(tx_valid),  int'(want.tx_valid));
    if (tx_byte   !== want.tx_byte)
      report_mismatch("tx_byte",   int'(tx_byte),   int'(want.tx_byte));
    if (rx_take   !== want.rx_take)
      report_mismatch("rx_take",   int'(rx_take),   int'(want.rx_take));
    if (irq_post  !== want.irq_post)
      report_mismatch("irq_post",  int'(irq_post),  int'(want.irq_post));
    if (irq_clear !== want.irq_clear)
      report_mismatch("irq_clear", int'(irq_clear), int'(want.irq_clear));
    results_checked++;
    posts_checked  += 32'(want.irq_post);
    clears_checked += 32'(want.irq_clear);
  endtask

  // Result side: check on each accepted word, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Every register, DLAB aliasing, read-only registers and the MCR filter
  task automatic test_register_map();
    bus_read(ADDR_IIR, 1'b0, 1'b0);
    bus_read(ADDR_LSR, 1'b0, 1'b1);
    bus_read(ADDR_LSR, 1'b1, 1'b0);
    bus_write(ADDR_SCR, 8'hFF, 1'b0);
    bus_read(ADDR_SCR, 1'b1, 1'b1);
    bus_write(ADDR_SCR, 8'h00, 1'b1);
    bus_read(ADDR_SCR, 1'b0, 1'b0);
    bus_write(ADDR_MCR, 8'h55, 1'b0);
    bus_read(ADDR_MCR, 1'b0, 1'b0);
    bus_write(ADDR_MCR, MCR_MATCH, 1'b1);
    bus_read(ADDR_MCR, 1'b0, 1'b0);
    bus_write(ADDR_LSR, 8'hFF, 1'b0);
    bus_write(ADDR_MSR, 8'hFF, 1'b1);
    bus_read(ADDR_MSR, 1'b1, 1'b1);
    bus_write(ADDR_IIR, 8'hC7, 1'b0);
    bus_write(ADDR_LCR, 8'h83, 1'b0);
    bus_write(ADDR_DATA, 8'hFF, 1'b1);
    bus_write(ADDR_IER, 8'hFF, 1'b1);
    bus_read(ADDR_DATA, 1'b1, 1'b1);
    bus_read(ADDR_IER, 1'b1, 1'b1);
    bus_read(ADDR_LCR, 1'b0, 1'b0);
    bus_write(ADDR_LCR, 8'h03, 1'b0);
    bus_write(ADDR_DATA, 8'hA5, 1'b0);
    bus_read(ADDR_DATA, 1'b1, 1'b0);
    // rx_more without rx_ready counts as nothing left
    bus_read(ADDR_DATA, 1'b0, 1'b1);
    bus_read(ADDR_IER, 1'b0, 1'b0);
    rx_arrival();
  endtask

  // Delayed interrupts, IIR priority, immediate TX fire and saturation
  task automatic test_interrupt_delay();
    bus_write(ADDR_IER, 8'h03, 1'b1);
    run_ticks(DELAY);
    bus_read(ADDR_IIR, 1'b0, 1'b0);
    bus_read(ADDR_DATA, 1'b1, 1'b1);
    bus_read(ADDR_IIR, 1'b0, 1'b0);
    bus_read(ADDR_IIR, 1'b0, 1'b0);
    // Interrupts off; the quiet-tick count runs into saturation
    bus_write(ADDR_IER, 8'h00, 1'b0);
    run_ticks(DELAY + 35);
    rx_arrival();
    bus_write(ADDR_IER, 8'h01, 1'b1);
    rx_arrival();
    // TX fires at once while RX pending is dropped: post and clear together
    bus_write(ADDR_IER, 8'h02, 1'b0);
    bus_read(ADDR_IIR, 1'b0, 1'b0);
    bus_write(ADDR_DATA, 8'h00, 1'b0);
    bus_write(ADDR_IER, 8'h02, 1'b1);
    bus_read(ADDR_IIR, 1'b1, 1'b0);
    bus_write(ADDR_IER, 8'h00, 1'b0);
  endtask

  // Mostly interrupt flows with random content, plus register traffic and noise
  task automatic test_random_mix(input int unsigned send_pct, input int unsigned stall_pct);
    int unsigned goal;
    int unsigned pick;
    logic [7:0]  data;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    goal = words_sent + PHASE_WORDS;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if (coin()) bus_write(ADDR_LCR, 8'($urandom) & 8'h7F, coin());
        repeat ($urandom_range(2, 7)) begin
          case ($urandom_range(5))
            0: bus_write(ADDR_IER, 8'($urandom), coin());
            1: rx_arrival();
            2: run_ticks($urandom_range(1, 12));
            3: bus_read(ADDR_IIR, coin(), coin());
            4: bus_read(ADDR_DATA, coin(), coin());
            default: bus_write(ADDR_DATA, 8'($urandom), coin());
          endcase
        end
      end else if (pick < 55) begin
        run_ticks($urandom_range(8, 30));
      end else if (pick < 85) begin
        data = ($urandom_range(7) == 0) ? MCR_MATCH : 8'($urandom);
        if (coin()) bus_write(3'($urandom), data, coin());
        else bus_read(3'($urandom), coin(), coin());
      end else if (pick < 97) begin
        send_word(random_word());
      end else begin
        wait_all_results();
      end
    end
    wait_all_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_register_map();
    test_interrupt_delay();
    wait_all_results();
    test_random_mix(0, 0);
    test_random_mix(88, 0);
    test_random_mix(0, 88);
    test_random_mix(35, 35);
    wait_all_results();
    repeat (4) @(posedge clk);
    $display("Sent %0d words (%0d ticks, %0d reads, %0d writes, %0d arrivals) under four",
             words_sent, words_by_cmd[CMD_TICK],
             words_by_cmd[CMD_READ], words_by_cmd[CMD_WRITE], words_by_cmd[CMD_ARRIVE]);
    $display("idle/stall profiles; %0d results checked, %0d posts, %0d clears, %0d mismatches",
             results_checked, posts_checked, clears_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
